// File: rtl/x86dec_pkg.sv
package x86dec_pkg;

	localparam int unsigned INSTR_MAX_LEN           = 6;
	localparam int unsigned LEN_W                   = 3;
	localparam int unsigned DEFAULT_MAX_INSTR_BYTES = 6;
	localparam int unsigned OUTQ_DEPTH              = 8;
	localparam int unsigned OUTQ_PTR_W              = $clog2(OUTQ_DEPTH);
	localparam int unsigned OUTQ_CNT_W              = $clog2(OUTQ_DEPTH + 1);

	typedef logic [7:0] byte_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef byte_t [INSTR_MAX_LEN-1:0] ibytes_t;

	// first-byte length codes
	localparam len_t LEN_NONE  = len_t'(0);
	localparam len_t LEN_MODRM = len_t'(1);

	// operand kinds
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_REG  = 3'd1;
	localparam logic [2:0] KIND_EA   = 3'd2;
	localparam logic [2:0] KIND_DIR  = 3'd3;
	localparam logic [2:0] KIND_IMM  = 3'd4;

	// operations
	localparam logic [4:0] OP_MOV     = 5'd0;
	localparam logic [4:0] OP_ADD     = 5'd1;
	localparam logic [4:0] OP_SUB     = 5'd2;
	localparam logic [4:0] OP_CMP     = 5'd3;
	localparam logic [4:0] OP_JE      = 5'd4;
	localparam logic [4:0] OP_JL      = 5'd5;
	localparam logic [4:0] OP_JLE     = 5'd6;
	localparam logic [4:0] OP_JB      = 5'd7;
	localparam logic [4:0] OP_JBE     = 5'd8;
	localparam logic [4:0] OP_JP      = 5'd9;
	localparam logic [4:0] OP_JO      = 5'd10;
	localparam logic [4:0] OP_JS      = 5'd11;
	localparam logic [4:0] OP_JNE     = 5'd12;
	localparam logic [4:0] OP_JNL     = 5'd13;
	localparam logic [4:0] OP_JNLE    = 5'd14;
	localparam logic [4:0] OP_JNB     = 5'd15;
	localparam logic [4:0] OP_JNBE    = 5'd16;
	localparam logic [4:0] OP_JNP     = 5'd17;
	localparam logic [4:0] OP_JNO     = 5'd18;
	localparam logic [4:0] OP_JNS     = 5'd19;
	localparam logic [4:0] OP_LOOP    = 5'd20;
	localparam logic [4:0] OP_LOOPZ   = 5'd21;
	localparam logic [4:0] OP_LOOPNZ  = 5'd22;
	localparam logic [4:0] OP_JCXZ    = 5'd23;
	localparam logic [4:0] OP_UNKNOWN = 5'd24;

	typedef struct packed {
		logic [4:0]         op_kind;
		logic               word_width;
		logic [2:0]         dst_kind;
		logic [3:0]         dst_reg;
		logic [2:0]         src_kind;
		logic [3:0]         src_reg;
		logic [2:0]         mem_form;
		logic               has_disp;
		logic signed [15:0] displacement;
		logic [15:0]        abs_addr;
		logic [15:0]        immediate;
		logic               last_in_run;
	} result_t;

	typedef struct packed {
		logic [1:0] num;
		result_t    res0;
		result_t    res1;
	} push_t;

	function automatic logic [15:0] sext8(byte_t b);
		return {{8{b[7]}}, b};
	endfunction

	function automatic logic is_regrm(byte_t b);
		return b[7:2] inside {6'h22, 6'h00, 6'h0A, 6'h0E};
	endfunction

	function automatic logic is_acc(byte_t b);
		return b[7:1] inside {7'h02, 7'h16, 7'h1E};
	endfunction

	function automatic logic is_movrm_imm(byte_t b);
		return b[7:1] == 7'h63;
	endfunction

	function automatic logic is_grp(byte_t b);
		return b[7:2] == 6'h20;
	endfunction

	function automatic len_t first_len(byte_t b);
		len_t l;
		if (is_regrm(b) || is_movrm_imm(b) || is_grp(b)) begin
			l = LEN_MODRM;
		end else if (b[7:4] == 4'hB) begin
			l = b[3] ? len_t'(3) : len_t'(2);
		end else if (is_acc(b)) begin
			l = b[0] ? len_t'(3) : len_t'(2);
		end else if (b[7:4] == 4'h7 || b[7:2] == 6'h38) begin
			l = len_t'(2);
		end else begin
			l = LEN_NONE;
		end
		return l;
	endfunction

	function automatic logic [1:0] disp_len(byte_t m);
		logic [1:0] d;
		if (m[7:6] == 2'd0 && m[2:0] == 3'd6) begin
			d = 2'd2;
		end else if (m[7:6] == 2'd1) begin
			d = 2'd1;
		end else if (m[7:6] == 2'd2) begin
			d = 2'd2;
		end else begin
			d = 2'd0;
		end
		return d;
	endfunction

	// zero when the reg extension is not supported
	function automatic len_t modrm_len(byte_t b0, byte_t b1);
		logic [2:0] r;
		len_t       base;
		len_t       l;
		r    = b1[5:3];
		base = len_t'(2) + len_t'(disp_len(b1));
		if (is_movrm_imm(b0)) begin
			l = (r != 3'd0) ? LEN_NONE : base + (b0[0] ? len_t'(2) : len_t'(1));
		end else if (is_grp(b0)) begin
			if (r != 3'd0 && r != 3'd5 && r != 3'd7) begin
				l = LEN_NONE;
			end else begin
				l = base + ((b0[1:0] == 2'd1) ? len_t'(2) : len_t'(1));
			end
		end else begin
			l = base;
		end
		return l;
	endfunction

	function automatic logic [4:0] jcc_kind(logic [3:0] c);
		logic [4:0] k;
		case (c)
			4'h0: k = OP_JO;
			4'h1: k = OP_JNO;
			4'h2: k = OP_JB;
			4'h3: k = OP_JNB;
			4'h4: k = OP_JE;
			4'h5: k = OP_JNE;
			4'h6: k = OP_JBE;
			4'h7: k = OP_JNBE;
			4'h8: k = OP_JS;
			4'h9: k = OP_JNS;
			4'hA: k = OP_JP;
			4'hB: k = OP_JNP;
			4'hC: k = OP_JL;
			4'hD: k = OP_JNL;
			4'hE: k = OP_JLE;
			4'hF: k = OP_JNLE;
			default: k = OP_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] loop_kind(logic [1:0] c);
		logic [4:0] k;
		case (c)
			2'd0: k = OP_LOOPNZ;
			2'd1: k = OP_LOOPZ;
			2'd2: k = OP_LOOP;
			2'd3: k = OP_JCXZ;
			default: k = OP_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic result_t unknown_result();
		result_t o;
		o         = '0;
		o.op_kind = OP_UNKNOWN;
		return o;
	endfunction

	function automatic result_t decode(ibytes_t bb);
		result_t    o;
		byte_t      b0;
		byte_t      m;
		logic       w;
		logic       grp;
		logic       s;
		logic       movr;
		logic [2:0] r;
		logic [2:0] rk;
		logic [3:0] rr;
		byte_t      ilo;
		byte_t      ihi;
		o    = '0;
		b0   = bb[0];
		m    = bb[1];
		r    = m[5:3];
		grp  = is_grp(b0);
		s    = grp & b0[1];
		movr = (b0[7:4] == 4'hB);
		w    = b0[0];
		rk   = KIND_NONE;
		rr   = '0;
		// r/m operand, displacement bytes from position 2
		if (m[7:6] == 2'd3) begin
			rk = KIND_REG;
			rr = {w, m[2:0]};
		end else if (m[7:6] == 2'd0 && m[2:0] == 3'd6) begin
			rk         = KIND_DIR;
			o.abs_addr = {bb[3], bb[2]};
		end else begin
			rk         = KIND_EA;
			o.mem_form = m[2:0];
			if (m[7:6] == 2'd1) begin
				o.has_disp     = 1'b1;
				o.displacement = sext8(bb[2]);
			end else if (m[7:6] == 2'd2) begin
				o.has_disp     = 1'b1;
				o.displacement = {bb[3], bb[2]};
			end
		end
		case (disp_len(m))
			2'd0: begin
				ilo = bb[2];
				ihi = bb[3];
			end
			2'd1: begin
				ilo = bb[3];
				ihi = bb[4];
			end
			default: begin
				ilo = bb[4];
				ihi = bb[5];
			end
		endcase
		if (is_regrm(b0)) begin
			case (b0[7:2])
				6'h22:   o.op_kind = OP_MOV;
				6'h00:   o.op_kind = OP_ADD;
				6'h0A:   o.op_kind = OP_SUB;
				default: o.op_kind = OP_CMP;
			endcase
			o.word_width = w;
			if (b0[1]) begin
				o.dst_kind = KIND_REG;
				o.dst_reg  = {w, r};
				o.src_kind = rk;
				o.src_reg  = rr;
			end else begin
				o.dst_kind = rk;
				o.dst_reg  = rr;
				o.src_kind = KIND_REG;
				o.src_reg  = {w, r};
			end
		end else if (is_movrm_imm(b0) || grp) begin
			if (!grp) begin
				o.op_kind = OP_MOV;
			end else if (r == 3'd0) begin
				o.op_kind = OP_ADD;
			end else if (r == 3'd5) begin
				o.op_kind = OP_SUB;
			end else begin
				o.op_kind = OP_CMP;
			end
			o.word_width = w;
			o.dst_kind   = rk;
			o.dst_reg    = rr;
			o.src_kind   = KIND_IMM;
			if (w && !s) begin
				o.immediate = {ihi, ilo};
			end else if (s) begin
				o.immediate = sext8(ilo);
			end else begin
				o.immediate = {8'h00, ilo};
			end
		end else if (movr || is_acc(b0)) begin
			o = '0;
			w = movr ? b0[3] : b0[0];
			if (movr) begin
				o.op_kind = OP_MOV;
			end else begin
				case (b0[7:1])
					7'h02:   o.op_kind = OP_ADD;
					7'h16:   o.op_kind = OP_SUB;
					default: o.op_kind = OP_CMP;
				endcase
			end
			o.word_width = w;
			o.dst_kind   = KIND_REG;
			o.dst_reg    = {w, movr ? b0[2:0] : 3'd0};
			o.src_kind   = KIND_IMM;
			o.immediate  = w ? {bb[2], bb[1]} : {8'h00, bb[1]};
		end else if (b0[7:4] == 4'h7) begin
			o              = '0;
			o.op_kind      = jcc_kind(b0[3:0]);
			o.displacement = sext8(m);
		end else if (b0[7:2] == 6'h38) begin
			o              = '0;
			o.op_kind      = loop_kind(b0[1:0]);
			o.displacement = sext8(m);
		end else begin
			o = unknown_result();
		end
		return o;
	endfunction

endpackage

// File: rtl/x86dec_if.sv
interface x86dec_code_if;
	import x86dec_pkg::*;
	logic  valid;
	logic  ready;
	byte_t code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

interface x86dec_dec_if;
	logic               valid;
	logic               ready;
	logic [4:0]         op_kind;
	logic               word_width;
	logic [2:0]         dst_kind;
	logic [3:0]         dst_reg;
	logic [2:0]         src_kind;
	logic [3:0]         src_reg;
	logic [2:0]         mem_form;
	logic               has_disp;
	logic signed [15:0] displacement;
	logic [15:0]        abs_addr;
	logic [15:0]        immediate;
	logic               last_in_run;

	modport source (
		output valid, op_kind, word_width, dst_kind, dst_reg, src_kind, src_reg,
		output mem_form, has_disp, displacement, abs_addr, immediate, last_in_run,
		input ready
	);
	modport sink (
		input valid, op_kind, word_width, dst_kind, dst_reg, src_kind, src_reg,
		input mem_form, has_disp, displacement, abs_addr, immediate, last_in_run,
		output ready
	);
endinterface

// File: rtl/x86_16bit_instruction_decoder_top.sv
// channel | dir | word                         | handshake
// code    | in  | one code byte                | valid/ready
// dec     | out | one decoded instruction      | valid/ready
//
// One code byte per cycle while the output queue has room. An accepted byte is registered, decoded
// against the instruction buffer in the next cycle, and its results enter an
// 8-word output queue, from which the dec channel reads them.
// A byte yields zero, one or two words. Ready drops when the queue cannot take
// two more words for the byte in decode and two for a new one.
// Reset clears the byte count and queue pointers; the byte buffer is not cleared.
module x86_16bit_instruction_decoder_top
	import x86dec_pkg::*;
#(
	parameter int unsigned MAX_INSTR_BYTES = DEFAULT_MAX_INSTR_BYTES
) (
	input logic          clk,
	input logic          arst_n,
	x86dec_code_if.sink  code,
	x86dec_dec_if.source dec
);

	logic                  vld_s1;
	byte_t                 byte_s1;
	push_t                 push;
	result_t               head;
	logic                  q_nempty;
	logic [OUTQ_CNT_W-1:0] q_level;
	logic [OUTQ_CNT_W:0]   q_need;

	assign q_need     = {1'b0, q_level} + (vld_s1 ? (OUTQ_CNT_W+1)'(2) : '0)
		+ (OUTQ_CNT_W+1)'(2);
	assign code.ready = (q_need <= (OUTQ_CNT_W+1)'(OUTQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= code.valid && code.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (code.valid && code.ready) begin
			byte_s1 <= code.code_byte;
		end
	end

	x86dec_core #(
		.MAX_INSTR_BYTES(MAX_INSTR_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.byte_s1 (byte_s1),
		.push    (push)
	);

	x86dec_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (dec.ready),
		.head      (head),
		.not_empty (q_nempty),
		.level     (q_level)
	);

	assign dec.valid        = q_nempty;
	assign dec.op_kind      = head.op_kind;
	assign dec.word_width   = head.word_width;
	assign dec.dst_kind     = head.dst_kind;
	assign dec.dst_reg      = head.dst_reg;
	assign dec.src_kind     = head.src_kind;
	assign dec.src_reg      = head.src_reg;
	assign dec.mem_form     = head.mem_form;
	assign dec.has_disp     = head.has_disp;
	assign dec.displacement = head.displacement;
	assign dec.abs_addr     = head.abs_addr;
	assign dec.immediate    = head.immediate;
	assign dec.last_in_run  = head.last_in_run;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= OUTQ_CNT_W'(OUTQ_DEPTH))
		else $error("output queue overflow");

	a_push_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		push.num != 2'd0 |-> vld_s1)
		else $error("result pushed without a byte in decode");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.num == 2'd2 |-> !push.res0.last_in_run && push.res1.last_in_run
			&& push.res0.op_kind == OP_UNKNOWN && push.res1.op_kind == OP_UNKNOWN)
		else $error("two-word run malformed");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.num == 2'd1 |-> push.res0.last_in_run)
		else $error("single word not marked last");

endmodule

// File: rtl/x86dec_core.sv
module x86dec_core
	import x86dec_pkg::*;
#(
	parameter int unsigned MAX_INSTR_BYTES = DEFAULT_MAX_INSTR_BYTES
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_s1,
	input  byte_t byte_s1,
	output push_t push
);

	localparam int unsigned CNT_W = $clog2(MAX_INSTR_BYTES + 1);
	localparam int unsigned IDX_W = $clog2(MAX_INSTR_BYTES);

	byte_t              buf_q [MAX_INSTR_BYTES];
	logic [CNT_W-1:0]   cnt_q;
	len_t               need_q;

	logic [CNT_W-1:0]   cnt_nx;
	logic [CNT_W-1:0]   cnt_inc;
	len_t               need_nx;
	len_t               need_v;
	len_t               len0;
	len_t               len1;
	len_t               len2;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic               restart;
	ibytes_t            bb;
	result_t            r0;
	result_t            r1;
	logic [1:0]         num;

	always_comb begin
		for (int i = 0; i < INSTR_MAX_LEN; i++) begin
			bb[i] = (cnt_q == CNT_W'(i)) ? byte_s1 : buf_q[i];
		end
	end

	assign len0 = first_len(byte_s1);
	assign len1 = modrm_len(buf_q[0], byte_s1);
	assign len2 = first_len(byte_s1);
	assign cnt_inc = cnt_q + CNT_W'(1);

	always_comb begin
		cnt_nx  = cnt_q;
		need_nx = need_q;
		need_v  = need_q;
		wr_en   = 1'b0;
		wr_idx  = cnt_q[IDX_W-1:0];
		restart = 1'b0;
		num     = 2'd0;
		r0      = unknown_result();
		r1      = unknown_result();
		if (vld_s1) begin
			if (cnt_q == '0) begin
				if (len0 == LEN_NONE) begin
					num = 2'd1;
				end else begin
					wr_en   = 1'b1;
					wr_idx  = '0;
					cnt_nx  = CNT_W'(1);
					need_nx = (len0 == LEN_MODRM) ? LEN_NONE : len0;
				end
			end else begin
				wr_en = 1'b1;
				if (cnt_inc == CNT_W'(2) && need_q == LEN_NONE) begin
					if (len1 == LEN_NONE) begin
						// unsupported reg extension: opcode is unknown, byte restarts
						restart = 1'b1;
						num     = 2'd1;
						if (len2 == LEN_NONE) begin
							wr_en   = 1'b0;
							num     = 2'd2;
							cnt_nx  = '0;
							need_nx = LEN_NONE;
						end else begin
							wr_idx  = '0;
							cnt_nx  = CNT_W'(1);
							need_nx = (len2 == LEN_MODRM) ? LEN_NONE : len2;
						end
					end else begin
						need_v = len1;
					end
				end
				if (!restart) begin
					if (need_v != LEN_NONE && cnt_inc >= CNT_W'(need_v)) begin
						r0      = decode(bb);
						num     = 2'd1;
						cnt_nx  = '0;
						need_nx = LEN_NONE;
					end else begin
						cnt_nx  = cnt_inc;
						need_nx = need_v;
					end
				end
			end
		end
		r0.last_in_run = (num == 2'd1);
		r1.last_in_run = 1'b1;
	end

	assign push.num  = num;
	assign push.res0 = r0;
	assign push.res1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			need_q <= LEN_NONE;
		end else begin
			cnt_q  <= cnt_nx;
			need_q <= need_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_idx] <= byte_s1;
		end
	end

endmodule

// File: rtl/x86dec_outq.sv
module x86dec_outq
	import x86dec_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  push_t                 push,
	input  logic                  pop,
	output result_t               head,
	output logic                  not_empty,
	output logic [OUTQ_CNT_W-1:0] level
);

	result_t                mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]  wp_q;
	logic [OUTQ_PTR_W-1:0]  rp_q;
	logic [OUTQ_CNT_W-1:0]  cnt_q;
	logic                   do_pop;

	assign not_empty = (cnt_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rp_q];
	assign level     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OUTQ_PTR_W'(push.num);
			rp_q  <= rp_q + OUTQ_PTR_W'(do_pop);
			cnt_q <= cnt_q + OUTQ_CNT_W'(push.num) - OUTQ_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wp_q] <= push.res0;
		end
		if (push.num == 2'd2) begin
			mem_q[wp_q + OUTQ_PTR_W'(1)] <= push.res1;
		end
	end

endmodule

// File: test/x86_16bit_instruction_decoder_top_test.sv
`timescale 1ns / 100ps

module x86_16bit_instruction_decoder_top_test;
	import x86dec_pkg::*;

	// opcode fields
	localparam logic [5:0] OPC_MOV_RM      = 6'h22;
	localparam logic [5:0] OPC_ADD_RM      = 6'h00;
	localparam logic [5:0] OPC_SUB_RM      = 6'h0A;
	localparam logic [5:0] OPC_CMP_RM      = 6'h0E;
	localparam logic [6:0] OPC_MOV_RM_IMM  = 7'h63;
	localparam logic [5:0] OPC_GRP_IMM     = 6'h20;
	localparam logic [3:0] OPC_MOV_REG_IMM = 4'hB;
	localparam logic [6:0] OPC_ADD_ACC     = 7'h02;
	localparam logic [6:0] OPC_SUB_ACC     = 7'h16;
	localparam logic [6:0] OPC_CMP_ACC     = 7'h1E;
	localparam logic [3:0] OPC_JCC         = 4'h7;
	localparam logic [5:0] OPC_LOOP        = 6'h38;

	// reg field extensions
	localparam logic [2:0] EXT_MOV = 3'd0;
	localparam logic [2:0] EXT_ADD = 3'd0;
	localparam logic [2:0] EXT_SUB = 3'd5;
	localparam logic [2:0] EXT_CMP = 3'd7;

	// ModR/M mod and r/m values
	localparam logic [1:0] MOD_MEM    = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP16 = 2'd2;
	localparam logic [1:0] MOD_REG    = 2'd3;
	localparam logic [2:0] RM_DIRECT  = 3'd6;

	// opcode length codes
	localparam int UNDECODABLE = 0;
	localparam int NEEDS_MODRM = 1;

	localparam logic [15:0][4:0] JCC_OPS = {
		OP_JNLE, OP_JLE, OP_JNL, OP_JL, OP_JNP, OP_JP, OP_JNS, OP_JS,
		OP_JNBE, OP_JBE, OP_JNE, OP_JE, OP_JNB, OP_JB, OP_JNO, OP_JO};
	localparam logic [3:0][4:0] LOOP_OPS = {OP_JCXZ, OP_LOOP, OP_LOOPZ, OP_LOOPNZ};
	localparam logic [3:0][5:0] RM_OPCODES = {OPC_CMP_RM, OPC_SUB_RM, OPC_ADD_RM, OPC_MOV_RM};
	localparam logic [2:0][6:0] ACC_OPCODES = {OPC_CMP_ACC, OPC_SUB_ACC, OPC_ADD_ACC};
	localparam logic [2:0][2:0] GOOD_EXTS = {EXT_CMP, EXT_SUB, EXT_ADD};
	localparam logic [4:0][2:0] BAD_EXTS = {3'd6, 3'd4, 3'd3, 3'd2, 3'd1};

	localparam int LONG_HOLD = 300;

	class decode_scoreboard;
		result_t pending_words[$];
		byte_t   held[INSTR_MAX_LEN];
		int      held_cnt;
		int      need_len;
		int      mismatches;
		int      words_checked;
		int      bytes_in;
		int      double_bytes;
		bit      ops_seen[32];

		function new();
			foreach (held[i]) held[i] = '0;
			held_cnt      = 0;
			need_len      = 0;
			mismatches    = 0;
			words_checked = 0;
			bytes_in      = 0;
			double_bytes  = 0;
		endfunction

		function logic [15:0] grow8(byte_t x);
			return {{8{x[7]}}, x};
		endfunction

		function bit rm_form(byte_t b);
			return b[7:2] == OPC_MOV_RM || b[7:2] == OPC_ADD_RM ||
				b[7:2] == OPC_SUB_RM || b[7:2] == OPC_CMP_RM;
		endfunction

		function bit acc_form(byte_t b);
			return b[7:1] == OPC_ADD_ACC || b[7:1] == OPC_SUB_ACC || b[7:1] == OPC_CMP_ACC;
		endfunction

		function int opcode_len(byte_t b);
			if (rm_form(b) || b[7:1] == OPC_MOV_RM_IMM || b[7:2] == OPC_GRP_IMM)
				return NEEDS_MODRM;
			if (b[7:4] == OPC_MOV_REG_IMM)
				return b[3] ? 3 : 2;
			if (acc_form(b))
				return b[0] ? 3 : 2;
			if (b[7:4] == OPC_JCC || b[7:2] == OPC_LOOP)
				return 2;
			return UNDECODABLE;
		endfunction

		function int disp_bytes(byte_t m);
			if (m[7:6] == MOD_MEM && m[2:0] == RM_DIRECT)
				return 2;
			if (m[7:6] == MOD_DISP8)
				return 1;
			if (m[7:6] == MOD_DISP16)
				return 2;
			return 0;
		endfunction

		// zero: reg extension not supported
		function int total_len(byte_t b0, byte_t m);
			int d;
			d = disp_bytes(m);
			if (b0[7:1] == OPC_MOV_RM_IMM) begin
				if (m[5:3] != EXT_MOV)
					return UNDECODABLE;
				return 2 + d + (b0[0] ? 2 : 1);
			end
			if (b0[7:2] == OPC_GRP_IMM) begin
				if (m[5:3] != EXT_ADD && m[5:3] != EXT_SUB && m[5:3] != EXT_CMP)
					return UNDECODABLE;
				return 2 + d + ((b0[1:0] == 2'b01) ? 2 : 1);
			end
			return 2 + d;
		endfunction

		function result_t bad_opcode_word();
			result_t o;
			o         = '0;
			o.op_kind = OP_UNKNOWN;
			return o;
		endfunction

		function void rm_part(byte_t m, logic w, inout result_t o,
				output logic [2:0] kind, output logic [3:0] regno);
			regno = '0;
			if (m[7:6] == MOD_REG) begin
				kind  = KIND_REG;
				regno = {w, m[2:0]};
			end else if (m[7:6] == MOD_MEM && m[2:0] == RM_DIRECT) begin
				kind       = KIND_DIR;
				o.abs_addr = {held[3], held[2]};
			end else begin
				kind       = KIND_EA;
				o.mem_form = m[2:0];
				if (m[7:6] == MOD_DISP8) begin
					o.has_disp     = 1'b1;
					o.displacement = grow8(held[2]);
				end else if (m[7:6] == MOD_DISP16) begin
					o.has_disp     = 1'b1;
					o.displacement = {held[3], held[2]};
				end
			end
		endfunction

		function result_t decode_held();
			result_t    o;
			byte_t      b0;
			byte_t      m;
			logic       w;
			logic       grp;
			logic       s;
			logic       movr;
			logic [2:0] kind;
			logic [3:0] regno;
			int         d;
			o  = '0;
			b0 = held[0];
			m  = held[1];
			w  = b0[0];
			if (rm_form(b0)) begin
				case (b0[7:2])
					OPC_MOV_RM: o.op_kind = OP_MOV;
					OPC_ADD_RM: o.op_kind = OP_ADD;
					OPC_SUB_RM: o.op_kind = OP_SUB;
					default:    o.op_kind = OP_CMP;
				endcase
				o.word_width = w;
				rm_part(m, w, o, kind, regno);
				if (b0[1]) begin
					o.dst_kind = KIND_REG;
					o.dst_reg  = {w, m[5:3]};
					o.src_kind = kind;
					o.src_reg  = regno;
				end else begin
					o.dst_kind = kind;
					o.dst_reg  = regno;
					o.src_kind = KIND_REG;
					o.src_reg  = {w, m[5:3]};
				end
			end else if (b0[7:1] == OPC_MOV_RM_IMM || b0[7:2] == OPC_GRP_IMM) begin
				grp = (b0[7:2] == OPC_GRP_IMM);
				s   = grp & b0[1];
				if (!grp)
					o.op_kind = OP_MOV;
				else if (m[5:3] == EXT_ADD)
					o.op_kind = OP_ADD;
				else if (m[5:3] == EXT_SUB)
					o.op_kind = OP_SUB;
				else
					o.op_kind = OP_CMP;
				o.word_width = w;
				rm_part(m, w, o, kind, regno);
				o.dst_kind = kind;
				o.dst_reg  = regno;
				o.src_kind = KIND_IMM;
				d = disp_bytes(m);
				if (w && !s)
					o.immediate = {held[3 + d], held[2 + d]};
				else if (s)
					o.immediate = grow8(held[2 + d]);
				else
					o.immediate = {8'h00, held[2 + d]};
			end else if (b0[7:4] == OPC_MOV_REG_IMM || acc_form(b0)) begin
				movr = (b0[7:4] == OPC_MOV_REG_IMM);
				w    = movr ? b0[3] : b0[0];
				if (movr)
					o.op_kind = OP_MOV;
				else if (b0[7:1] == OPC_ADD_ACC)
					o.op_kind = OP_ADD;
				else if (b0[7:1] == OPC_SUB_ACC)
					o.op_kind = OP_SUB;
				else
					o.op_kind = OP_CMP;
				o.word_width = w;
				o.dst_kind   = KIND_REG;
				o.dst_reg    = {w, movr ? b0[2:0] : 3'd0};
				o.src_kind   = KIND_IMM;
				o.immediate  = w ? {held[2], held[1]} : {8'h00, held[1]};
			end else if (b0[7:4] == OPC_JCC) begin
				o.op_kind      = JCC_OPS[b0[3:0]];
				o.displacement = grow8(m);
			end else if (b0[7:2] == OPC_LOOP) begin
				o.op_kind      = LOOP_OPS[b0[1:0]];
				o.displacement = grow8(m);
			end else begin
				o = bad_opcode_word();
			end
			return o;
		endfunction

		function void restart(byte_t b);
			int len;
			len      = opcode_len(b);
			held_cnt = 0;
			need_len = 0;
			if (len == UNDECODABLE) begin
				pending_words.push_back(bad_opcode_word());
			end else begin
				held[0]  = b;
				held_cnt = 1;
				need_len = (len == NEEDS_MODRM) ? 0 : len;
			end
		endfunction

		function void note_byte(byte_t b);
			int      prior;
			int      len;
			result_t tail;
			prior = pending_words.size();
			bytes_in++;
			if (held_cnt == 0) begin
				restart(b);
			end else begin
				if (held_cnt < INSTR_MAX_LEN) begin
					held[held_cnt] = b;
					held_cnt++;
				end
				if (held_cnt == 2 && need_len == 0) begin
					len = total_len(held[0], b);
					if (len == UNDECODABLE) begin
						pending_words.push_back(bad_opcode_word());
						restart(b);
					end else begin
						need_len = len;
					end
				end
			end
			if (need_len != 0 && held_cnt >= need_len) begin
				pending_words.push_back(decode_held());
				held_cnt = 0;
				need_len = 0;
			end
			if (pending_words.size() > prior) begin
				tail             = pending_words.pop_back();
				tail.last_in_run = 1'b1;
				pending_words.push_back(tail);
			end
			if (pending_words.size() - prior == 2)
				double_bytes++;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s", msg);
		endfunction

		function void check_word(result_t got);
			result_t want;
			string   diffs;
			words_checked++;
			if (pending_words.size() == 0) begin
				report($sformatf("word %0d arrived with nothing pending (op_kind %0d)",
					words_checked, got.op_kind));
				return;
			end
			want = pending_words.pop_front();
			ops_seen[want.op_kind] = 1'b1;
			diffs = "";
			if (got.op_kind !== want.op_kind)
				diffs = {diffs, $sformatf(" op_kind %0d/%0d", want.op_kind, got.op_kind)};
			if (got.word_width !== want.word_width)
				diffs = {diffs, $sformatf(" word_width %0d/%0d", want.word_width, got.word_width)};
			if (got.dst_kind !== want.dst_kind)
				diffs = {diffs, $sformatf(" dst_kind %0d/%0d", want.dst_kind, got.dst_kind)};
			if (got.dst_reg !== want.dst_reg)
				diffs = {diffs, $sformatf(" dst_reg %0d/%0d", want.dst_reg, got.dst_reg)};
			if (got.src_kind !== want.src_kind)
				diffs = {diffs, $sformatf(" src_kind %0d/%0d", want.src_kind, got.src_kind)};
			if (got.src_reg !== want.src_reg)
				diffs = {diffs, $sformatf(" src_reg %0d/%0d", want.src_reg, got.src_reg)};
			if (got.mem_form !== want.mem_form)
				diffs = {diffs, $sformatf(" mem_form %0d/%0d", want.mem_form, got.mem_form)};
			if (got.has_disp !== want.has_disp)
				diffs = {diffs, $sformatf(" has_disp %0d/%0d", want.has_disp, got.has_disp)};
			if (got.displacement !== want.displacement)
				diffs = {diffs, $sformatf(" displacement %0d/%0d",
					want.displacement, got.displacement)};
			if (got.abs_addr !== want.abs_addr)
				diffs = {diffs, $sformatf(" abs_addr %h/%h", want.abs_addr, got.abs_addr)};
			if (got.immediate !== want.immediate)
				diffs = {diffs, $sformatf(" immediate %h/%h", want.immediate, got.immediate)};
			if (got.last_in_run !== want.last_in_run)
				diffs = {diffs, $sformatf(" last_in_run %0d/%0d", want.last_in_run, got.last_in_run)};
			if (diffs != "")
				report($sformatf("word %0d (expected/actual):%s", words_checked, diffs));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	x86dec_code_if code_ch ();
	x86dec_dec_if  dec_ch ();

	x86_16bit_instruction_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code_ch),
		.dec    (dec_ch)
	);

	decode_scoreboard sb;
	byte_t stream[$];
	int    src_idle = 0;
	int    sink_stall = 0;
	bit    hold_req = 1'b0;
	bit    sink_hold = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic send_byte(input byte_t b);
		while ($urandom_range(99) < src_idle) begin
			code_ch.valid <= 1'b0;
			@(posedge clk);
		end
		code_ch.valid     <= 1'b1;
		code_ch.code_byte <= b;
		do @(posedge clk); while (!code_ch.ready);
		sb.note_byte(b);
	endtask

	task automatic wait_drained();
		code_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_words.size() != 0);
	endtask

	function automatic void push_random(int n);
		repeat (n) stream.push_back(byte_t'($urandom_range(255)));
	endfunction

	// one instruction: mostly well formed, some noise and bad reg extensions
	function automatic void build_instr();
		byte_t op;
		byte_t m;
		int    pick;
		pick = $urandom_range(99);
		m    = byte_t'($urandom_range(255));
		if (pick < 8) begin
			stream.push_back(m);
			return;
		end
		if (pick < 14) begin
			if ($urandom_range(1)) begin
				op      = {OPC_GRP_IMM, 2'($urandom_range(3))};
				m[5:3]  = BAD_EXTS[$urandom_range(4)];
			end else begin
				op      = {OPC_MOV_RM_IMM, 1'($urandom_range(1))};
				m[5:3]  = 3'($urandom_range(7, 1));
			end
			stream.push_back(op);
			stream.push_back(m);
			return;
		end
		case ($urandom_range(6))
			0: begin
				op = {RM_OPCODES[$urandom_range(3)], 2'($urandom_range(3))};
				stream.push_back(op);
				stream.push_back(m);
				push_random(sb.disp_bytes(m));
			end
			1: begin
				op     = {OPC_MOV_RM_IMM, 1'($urandom_range(1))};
				m[5:3] = EXT_MOV;
				stream.push_back(op);
				stream.push_back(m);
				push_random(sb.disp_bytes(m) + (op[0] ? 2 : 1));
			end
			2: begin
				op     = {OPC_GRP_IMM, 2'($urandom_range(3))};
				m[5:3] = GOOD_EXTS[$urandom_range(2)];
				stream.push_back(op);
				stream.push_back(m);
				push_random(sb.disp_bytes(m) + ((op[1:0] == 2'b01) ? 2 : 1));
			end
			3: begin
				op = {OPC_MOV_REG_IMM, 4'($urandom_range(15))};
				stream.push_back(op);
				push_random(op[3] ? 2 : 1);
			end
			4: begin
				op = {ACC_OPCODES[$urandom_range(2)], 1'($urandom_range(1))};
				stream.push_back(op);
				push_random(op[0] ? 2 : 1);
			end
			5: begin
				stream.push_back({OPC_JCC, 4'($urandom_range(15))});
				stream.push_back(m);
			end
			default: begin
				stream.push_back({OPC_LOOP, 2'($urandom_range(3))});
				stream.push_back(m);
			end
		endcase
	endfunction

	task automatic random_phase(input int n_bytes, input int idle, input int stall);
		int sent;
		src_idle   = idle;
		sink_stall = stall;
		sent       = 0;
		while (sent < n_bytes) begin
			build_instr();
			sent += stream.size();
			while (stream.size() != 0)
				send_byte(stream.pop_front());
		end
		wait_drained();
	endtask

	// decoded word sink
	initial begin : sink
		result_t got;
		dec_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (dec_ch.valid && dec_ch.ready) begin
				got = {dec_ch.op_kind, dec_ch.word_width, dec_ch.dst_kind, dec_ch.dst_reg,
					dec_ch.src_kind, dec_ch.src_reg, dec_ch.mem_form, dec_ch.has_disp,
					dec_ch.displacement, dec_ch.abs_addr, dec_ch.immediate,
					dec_ch.last_in_run};
				sb.check_word(got);
			end
			dec_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_stall);
		end
	end

	// long back-pressure stretch so the output queue fills and stalls code input
	initial begin : hold_off
		wait (hold_req);
		sink_hold = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		sink_hold = 1'b0;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Timeout with %0d words still pending", sb.pending_words.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : main
		int kinds;
		sb = new();
		code_ch.valid     <= 1'b0;
		code_ch.code_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stream = {
			8'hFF,
			8'h00, 8'hC0,
			8'h8B, 8'h06, 8'h34, 8'h12,
			8'h89, 8'h47, 8'h80,
			8'h2B, 8'h98, 8'hFF, 8'h7F,
			8'h3A, 8'h00,
			8'hC6, 8'h06, 8'hFF, 8'hFF, 8'hAB,
			8'hC7, 8'h80, 8'h00, 8'h80, 8'h34, 8'h12,
			8'h81, 8'hC3, 8'hFF, 8'hFF,
			8'h80, 8'h2F, 8'h05,
			8'h83, 8'hFF, 8'h80,
			8'h82, 8'hC0, 8'hFF,
			8'h83, 8'h40, 8'h7F, 8'h80,
			8'hB0, 8'h00,
			8'hBF, 8'hFF, 8'hFF,
			8'h04, 8'hFF,
			8'h2D, 8'h00, 8'h80,
			8'h3C, 8'h7F,
			8'h70, 8'h7F,
			8'h7F, 8'h80,
			8'hE0, 8'hFE,
			8'hE3, 8'h00,
			8'h80, 8'h08,
			8'hC7, 8'hB0, 8'h12,
			8'h0F
		};
		while (stream.size() != 0)
			send_byte(stream.pop_front());
		wait_drained();

		hold_req = 1'b1;
		random_phase(430, 0, 0);
		random_phase(430, 78, 0);
		random_phase(430, 0, 78);
		random_phase(430, 33, 33);
		sink_stall = 0;
		repeat (20) @(posedge clk);

		kinds = 0;
		for (int i = 0; i < 32; i++)
			if (sb.ops_seen[i])
				kinds++;
		$display("Run covered %0d code bytes and %0d decoded words, %0d of 25 operation kinds,",
			sb.bytes_in, sb.words_checked, kinds);
		$display("%0d bytes that gave two words, %0d mismatching words.",
			sb.double_bytes, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_words.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
